[sv/sha1de_pkg.sv]
// ============================================================================
// SHA-1 digest engine package
// Shared types, state codes and constants for the SHA-1 digest engine.
// ============================================================================
`timescale 1ns / 1ps

package sha1de_pkg;

  // Initial chaining value.
  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hefcdab89;
  localparam logic [31:0] IV2 = 32'h98badcfe;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hc3d2e1f0;

  // Round constants, one for each group of twenty rounds.
  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;

  localparam logic [6:0] ROUND_G1   = 7'd20;
  localparam logic [6:0] ROUND_G2   = 7'd40;
  localparam logic [6:0] ROUND_G3   = 7'd60;
  localparam logic [6:0] LAST_ROUND = 7'd79;

  localparam logic [7:0] PAD_MARKER = 8'h80;
  localparam logic [5:0] LEN_START  = 6'd56;
  localparam logic [5:0] LAST_POS   = 6'd63;

  // UUID version 5 and variant fields.
  localparam logic [31:0] UUID_VER_MASK = 32'hffff0fff;
  localparam logic [31:0] UUID_VER_BITS = 32'h00005000;
  localparam logic [31:0] UUID_VAR_MASK = 32'h3fffffff;
  localparam logic [31:0] UUID_VAR_BITS = 32'h80000000;

  localparam logic [2:0] LAST_IDX_FULL = 3'd4;
  localparam logic [2:0] LAST_IDX_UUID = 3'd3;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } regs_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_OUT
  } state_t;

  // Per-cycle control from the sequencer to the datapath.
  typedef struct packed {
    logic in_rdy;
    logic shift_byte;
    logic byte_from_pad;
    logic load_rr;
    logic round_en;
    logic add_cv;
    logic out_load;
  } ctl_t;

endpackage

[sv/sha1de_wsched.sv]
// ============================================================================
// SHA-1 block store and message schedule
// Packs bytes into a 16-word window and extends the schedule one word a round.
// ============================================================================
`timescale 1ns / 1ps

module sha1de_wsched (
  input  logic        clk,
  input  logic        shift_byte,
  input  logic [7:0]  data_in,
  input  logic        shift_word,
  output logic [31:0] w_top
);

  // Word i of the window sits at bits [511-32i -: 32]; word 0 is the oldest.
  logic [511:0] blk_r;
  logic [511:0] blk_nxt;
  logic [31:0]  mix;
  logic [31:0]  w_new;

  assign w_top = blk_r[511:480];
  assign mix   = blk_r[95:64] ^ blk_r[255:224] ^ blk_r[447:416] ^ blk_r[511:480];
  assign w_new = {mix[30:0], mix[31]};

  always_comb begin
    blk_nxt = blk_r;
    if (shift_byte) begin
      blk_nxt = {blk_r[503:0], data_in};
    end else if (shift_word) begin
      blk_nxt = {blk_r[479:0], w_new};
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
  end

endmodule

[sv/sha1de_round.sv]
// ============================================================================
// SHA-1 round unit
// One SHA-1 round: boolean function, constant selection and the five-way add.
// ============================================================================
`timescale 1ns / 1ps

module sha1de_round (
  input  sha1de_pkg::regs_t cur,
  input  logic [31:0]       w,
  input  logic [6:0]        rnd,
  output sha1de_pkg::regs_t nxt
);

  logic [31:0] f;
  logic [31:0] k;

  always_comb begin
    if (rnd < sha1de_pkg::ROUND_G1) begin
      f = (cur.b & cur.c) | (~cur.b & cur.d);
      k = sha1de_pkg::K0;
    end else if (rnd < sha1de_pkg::ROUND_G2) begin
      f = cur.b ^ cur.c ^ cur.d;
      k = sha1de_pkg::K1;
    end else if (rnd < sha1de_pkg::ROUND_G3) begin
      f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
      k = sha1de_pkg::K2;
    end else begin
      f = cur.b ^ cur.c ^ cur.d;
      k = sha1de_pkg::K3;
    end
  end

  always_comb begin
    nxt.a = {cur.a[26:0], cur.a[31:27]} + f + cur.e + k + w;
    nxt.b = cur.a;
    nxt.c = {cur.b[1:0], cur.b[31:2]};
    nxt.d = cur.c;
    nxt.e = cur.d;
  end

endmodule

[sv/sha1_digest_engine_core.sv]
// ============================================================================
// SHA-1 digest engine
// Byte-serial SHA-1 hash with padding, digest word output and UUID v5 mode.
// ============================================================================
//
// Channel   Direction  Ports                     Content
// in_       slave      tvalid/tready/tdata/      one message byte, byte flag,
//                      tuser/tlast               end of message
// out_      master     tvalid/tready/tdata/      one digest word, its index,
//                      tuser/tlast               last word flag
// cfg_      write      wr_en/wr_data             uuid_mode register
//
// A plain byte or an idle item is taken while the engine is idle. The 64th byte
// of a block is followed by a compression: the accept, 80 rounds through the
// one shared round unit and an add into the chaining value. An end item then
// adds the padding bytes (9 to 72), one or two padding compressions, and the
// digest words, one per cycle while out_tready is high. Synchronous active-low
// reset returns the block to idle with the initial chaining value; the block store has none.
// ============================================================================
`timescale 1ns / 1ps

module sha1_digest_engine_core (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration.
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,   // uuid_mode
  // Message input.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // [7:0] data_byte
  input  logic        in_tuser,      // [0] byte_present
  input  logic        in_tlast,      // end_of_message
  // Digest output.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,     // [31:0] digest_word
  output logic [2:0]  out_tuser,     // [2:0] word_index
  output logic        out_tlast      // last_word
);

  sha1de_pkg::state_t state_r, state_nxt;
  sha1de_pkg::ctl_t   ctl;

  sha1de_pkg::regs_t  cv_r, cv_nxt;
  sha1de_pkg::regs_t  rr_r, rr_nxt;
  sha1de_pkg::regs_t  round_out;

  logic        uuid_mode_r, uuid_mode_nxt;
  logic [63:0] len_r, len_nxt;
  logic [5:0]  count_r, count_nxt;
  logic [6:0]  rnd_r, rnd_nxt;
  logic        pad_act_r, pad_act_nxt;
  logic        mark_r, mark_nxt;
  logic        len_ph_r, len_ph_nxt;
  logic [2:0]  wcnt_r, wcnt_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_data_r, out_data_nxt;
  logic [2:0]  out_idx_r, out_idx_nxt;
  logic        out_last_r, out_last_nxt;

  logic        accept;
  logic        block_full;
  logic [7:0]  pad_byte;
  logic [7:0]  store_byte;
  logic [31:0] w_top;
  logic [2:0]  last_idx;
  logic [31:0] word_sel;

  assign accept     = in_tvalid && in_tready;
  assign in_tready  = ctl.in_rdy;
  assign block_full = (count_r == sha1de_pkg::LAST_POS);
  assign last_idx   = uuid_mode_r ? sha1de_pkg::LAST_IDX_UUID : sha1de_pkg::LAST_IDX_FULL;

  // Padding byte: the marker first, then zeros up to byte 56 of a block,
  // then the bit length most significant byte first.
  always_comb begin
    if (!mark_r) begin
      pad_byte = sha1de_pkg::PAD_MARKER;
    end else if (len_ph_r || (count_r == sha1de_pkg::LEN_START)) begin
      pad_byte = len_r[{~count_r[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  assign store_byte = ctl.byte_from_pad ? pad_byte : in_tdata;

  sha1de_wsched u_wsched (
    .clk        (clk),
    .shift_byte (ctl.shift_byte),
    .data_in    (store_byte),
    .shift_word (ctl.round_en),
    .w_top      (w_top)
  );

  sha1de_round u_round (
    .cur (rr_r),
    .w   (w_top),
    .rnd (rnd_r),
    .nxt (round_out)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sha1de_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_tuser && block_full) begin
            state_nxt = sha1de_pkg::ST_ROUND;
          end else if (in_tlast) begin
            state_nxt = sha1de_pkg::ST_PAD;
          end
        end
      end
      sha1de_pkg::ST_ROUND: begin
        if (rnd_r == sha1de_pkg::LAST_ROUND) begin
          state_nxt = sha1de_pkg::ST_ADD;
        end
      end
      sha1de_pkg::ST_ADD: begin
        if (!pad_act_r) begin
          state_nxt = sha1de_pkg::ST_IDLE;
        end else if (len_ph_r) begin
          state_nxt = sha1de_pkg::ST_OUT;
        end else begin
          state_nxt = sha1de_pkg::ST_PAD;
        end
      end
      sha1de_pkg::ST_PAD: begin
        if (block_full) begin
          state_nxt = sha1de_pkg::ST_ROUND;
        end
      end
      sha1de_pkg::ST_OUT: begin
        if ((!out_valid_r || out_tready) && (wcnt_r == last_idx)) begin
          state_nxt = sha1de_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sha1de_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs. In idle the input is always ready, so tvalid alone
  // marks an accepted item.
  always_comb begin
    ctl = '0;
    unique case (state_r)
      sha1de_pkg::ST_IDLE: begin
        ctl.in_rdy     = 1'b1;
        ctl.shift_byte = in_tvalid && in_tuser;
        ctl.load_rr    = in_tvalid && in_tuser && block_full;
      end
      sha1de_pkg::ST_ROUND: begin
        ctl.round_en = 1'b1;
      end
      sha1de_pkg::ST_ADD: begin
        ctl.add_cv = 1'b1;
      end
      sha1de_pkg::ST_PAD: begin
        ctl.shift_byte    = 1'b1;
        ctl.byte_from_pad = 1'b1;
        ctl.load_rr       = block_full;
      end
      sha1de_pkg::ST_OUT: begin
        ctl.out_load = !out_valid_r || out_tready;
      end
      default: ctl = '0;
    endcase
  end

  // Digest word selection, with the UUID version and variant fields forced.
  always_comb begin
    case (wcnt_r)
      3'd0:    word_sel = cv_r.a;
      3'd1:    word_sel = uuid_mode_r ?
                 ((cv_r.b & sha1de_pkg::UUID_VER_MASK) | sha1de_pkg::UUID_VER_BITS) : cv_r.b;
      3'd2:    word_sel = uuid_mode_r ?
                 ((cv_r.c & sha1de_pkg::UUID_VAR_MASK) | sha1de_pkg::UUID_VAR_BITS) : cv_r.c;
      3'd3:    word_sel = cv_r.d;
      default: word_sel = cv_r.e;
    endcase
  end

  // Datapath next values.
  always_comb begin
    uuid_mode_nxt = cfg_wr_en ? cfg_wr_data : uuid_mode_r;
    cv_nxt        = cv_r;
    rr_nxt        = rr_r;
    len_nxt       = len_r;
    count_nxt     = count_r;
    rnd_nxt       = rnd_r;
    pad_act_nxt   = pad_act_r;
    mark_nxt      = mark_r;
    len_ph_nxt    = len_ph_r;
    wcnt_nxt      = wcnt_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    out_data_nxt  = out_data_r;
    out_idx_nxt   = out_idx_r;
    out_last_nxt  = out_last_r;

    if (accept) begin
      if (in_tuser) begin
        len_nxt = len_r + 64'd8;
      end
      if (in_tlast) begin
        pad_act_nxt = 1'b1;
      end
    end

    if (ctl.shift_byte) begin
      count_nxt = count_r + 6'd1;
    end

    if (ctl.byte_from_pad) begin
      mark_nxt = 1'b1;
      if (mark_r && (count_r == sha1de_pkg::LEN_START)) begin
        len_ph_nxt = 1'b1;
      end
    end

    if (ctl.load_rr) begin
      rr_nxt  = cv_r;
      rnd_nxt = 7'd0;
    end else if (ctl.round_en) begin
      rr_nxt  = round_out;
      rnd_nxt = rnd_r + 7'd1;
    end

    if (ctl.add_cv) begin
      cv_nxt.a = cv_r.a + rr_r.a;
      cv_nxt.b = cv_r.b + rr_r.b;
      cv_nxt.c = cv_r.c + rr_r.c;
      cv_nxt.d = cv_r.d + rr_r.d;
      cv_nxt.e = cv_r.e + rr_r.e;
    end

    if (ctl.out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = word_sel;
      out_idx_nxt   = wcnt_r;
      out_last_nxt  = (wcnt_r == last_idx);
      wcnt_nxt      = wcnt_r + 3'd1;
      if (wcnt_r == last_idx) begin
        // Message done: back to the start state for the next one.
        cv_nxt      = '{sha1de_pkg::IV0, sha1de_pkg::IV1, sha1de_pkg::IV2,
                        sha1de_pkg::IV3, sha1de_pkg::IV4};
        len_nxt     = 64'd0;
        count_nxt   = 6'd0;
        pad_act_nxt = 1'b0;
        mark_nxt    = 1'b0;
        len_ph_nxt  = 1'b0;
        wcnt_nxt    = 3'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sha1de_pkg::ST_IDLE;
      uuid_mode_r <= 1'b0;
      cv_r        <= '{sha1de_pkg::IV0, sha1de_pkg::IV1, sha1de_pkg::IV2,
                       sha1de_pkg::IV3, sha1de_pkg::IV4};
      len_r       <= 64'd0;
      count_r     <= 6'd0;
      rnd_r       <= 7'd0;
      pad_act_r   <= 1'b0;
      mark_r      <= 1'b0;
      len_ph_r    <= 1'b0;
      wcnt_r      <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      uuid_mode_r <= uuid_mode_nxt;
      cv_r        <= cv_nxt;
      len_r       <= len_nxt;
      count_r     <= count_nxt;
      rnd_r       <= rnd_nxt;
      pad_act_r   <= pad_act_nxt;
      mark_r      <= mark_nxt;
      len_ph_r    <= len_ph_nxt;
      wcnt_r      <= wcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rr_r       <= rr_nxt;
    out_data_r <= out_data_nxt;
    out_idx_r  <= out_idx_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_idx_r;
  assign out_tlast  = out_last_r;

endmodule

[dv/tb.sv]
// ============================================================================
// SHA-1 digest engine testbench
// Streams messages into the engine one byte per item and checks every digest
// word against a SHA-1 model kept inside the bench or a known digest typed in,
// in both digest and UUID modes, with random input gaps and random output stalls.
// ============================================================================
`timescale 1ns / 1ps

module tb;

  localparam int SETTLE_CYCLES = 120;          // longer than one compression
  localparam int TIMEOUT_NS    = 5_000_000;

  // Known digests for the table rows that can be checked without the model.
  localparam logic [159:0] EMPTY_DIGEST = 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709;
  localparam logic [159:0] ABC_DIGEST   = 160'ha9993e364706816aba3e25717850c26c9cd0d89d;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  typedef struct packed {
    logic [7:0]   data;
    logic         present;
    logic         eom;
    logic         known;      // digest typed in below rather than predicted
    logic [159:0] digest;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tuser = 1'b0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  int tx_gap_pct = 0;
  int rx_stall_pct = 0;
  int error_count = 0;

  digest_word_t pending_words[$];

  // Model state: block store, chaining value, length and byte position.
  logic [31:0] blk_w [16];
  logic [31:0] chain [5];
  logic [63:0] bit_len;
  logic [5:0]  byte_pos;
  logic        uuid_en;

  // Directed items: empty message, idle item, "abc", field extremes,
  // a bare end after bytes, a single byte carrying the end, and a bare end
  // whose ignored data byte is all ones.
  directed_row_t directed_rows [11] = '{
    {8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
    {8'hff, 1'b0, 1'b0, 1'b0, 160'h0},
    {8'h61, 1'b1, 1'b0, 1'b0, 160'h0},
    {8'h62, 1'b1, 1'b0, 1'b0, 160'h0},
    {8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},
    {8'h00, 1'b1, 1'b0, 1'b0, 160'h0},
    {8'hff, 1'b1, 1'b0, 1'b0, 160'h0},
    {8'h5a, 1'b0, 1'b0, 1'b0, 160'h0},
    {8'ha5, 1'b0, 1'b1, 1'b0, 160'h0},
    {8'hff, 1'b1, 1'b1, 1'b0, 160'h0},
    {8'hff, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST}
  };

  sha1_digest_engine_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // SHA-1 model
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] rol(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic void restart_message();
    chain[0] = sha1de_pkg::IV0;
    chain[1] = sha1de_pkg::IV1;
    chain[2] = sha1de_pkg::IV2;
    chain[3] = sha1de_pkg::IV3;
    chain[4] = sha1de_pkg::IV4;
    bit_len  = '0;
    byte_pos = '0;
  endfunction

  // Eighty rounds over the current block, added into the chaining value.
  function automatic void sha1_compress();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, wi, t;
    int r;
    for (r = 0; r < 16; r++) w[r] = blk_w[r];
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    e = chain[4];
    for (r = 0; r < 80; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = sha1de_pkg::K0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = sha1de_pkg::K1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = sha1de_pkg::K2;
      end else begin
        f = b ^ c ^ d;
        k = sha1de_pkg::K3;
      end
      if (r < 16) begin
        wi = w[r];
      end else begin
        wi = rol(w[(r - 3) & 15] ^ w[(r - 8) & 15] ^ w[(r - 14) & 15] ^ w[r & 15], 1);
        w[r & 15] = wi;
      end
      t = rol(a, 5) + f + e + k + wi;
      e = d;
      d = c;
      c = rol(b, 30);
      b = a;
      a = t;
    end
    chain[0] += a;
    chain[1] += b;
    chain[2] += c;
    chain[3] += d;
    chain[4] += e;
  endfunction

  // Big-endian packing; the 64th byte of a block triggers compression.
  function automatic void absorb_byte(input logic [7:0] v);
    int sh;
    sh = 24 - 8 * byte_pos[1:0];
    if (byte_pos[1:0] == 2'd0) blk_w[byte_pos[5:2]] = '0;
    blk_w[byte_pos[5:2]] = blk_w[byte_pos[5:2]] | ({24'h0, v} << sh);
    if (byte_pos == sha1de_pkg::LAST_POS) sha1_compress();
    byte_pos = byte_pos + 6'd1;
  endfunction

  // Takes one input item and returns how many digest words it releases.
  function automatic int sha1_absorb(input logic [7:0] b, input logic present, input logic eom,
                                     output logic [4:0][31:0] words);
    logic [63:0] len;
    int s, n;
    words = '0;
    if (present) begin
      absorb_byte(b);
      bit_len += 64'd8;
    end
    if (!eom) return 0;
    len = bit_len;
    absorb_byte(sha1de_pkg::PAD_MARKER);
    while (byte_pos != sha1de_pkg::LEN_START) absorb_byte(8'h00);
    for (s = 7; s >= 0; s--) absorb_byte(len[8*s +: 8]);
    for (s = 0; s < 5; s++) words[s] = chain[s];
    // The mode is taken when the message closes, not when it starts.
    if (uuid_en) begin
      words[1] = (words[1] & sha1de_pkg::UUID_VER_MASK) | sha1de_pkg::UUID_VER_BITS;
      words[2] = (words[2] & sha1de_pkg::UUID_VAR_MASK) | sha1de_pkg::UUID_VAR_BITS;
      n = 4;
    end else begin
      n = 5;
    end
    restart_message();
    return n;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Drives one item, waits for it to be taken and queues the digest words it
  // should release. Handshakes are looked at on the falling edge, where
  // everything driven at the previous rising edge has settled.
  task automatic send_item(input logic [7:0] b, input logic present, input logic eom,
                           input logic known, input logic [159:0] known_digest);
    logic [4:0][31:0] words;
    digest_word_t entry;
    int n, j;
    while ($urandom_range(99) < tx_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= present;
    in_tlast  <= eom;
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    n = sha1_absorb(b, present, eom, words);
    for (j = 0; j < n; j++) begin
      entry.word  = known ? known_digest[159 - 32*j -: 32] : words[j];
      entry.index = 3'(j);
      entry.last  = (j == n - 1);
      pending_words = {pending_words, entry};
    end
  endtask

  // Holds the input back until every queued digest word has come out.
  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_words.size() != 0);
  endtask

  // Writes uuid_mode once the engine has gone quiet.
  task automatic set_uuid_mode(input logic mode);
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    uuid_en = mode;
  endtask

  // One message of random content. The end travels either with the last
  // byte or as a bare end item; idle items are scattered in as noise.
  task automatic send_message(input int len, output int used);
    logic with_byte;
    int i;
    with_byte = (len > 0) && ($urandom_range(1) == 1);
    used = 0;
    for (i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) begin
        send_item(8'($urandom), 1'b0, 1'b0, 1'b0, '0);
        used++;
      end
      send_item(8'($urandom), 1'b1, with_byte && (i == len - 1), 1'b0, '0);
      used++;
    end
    if (!with_byte) begin
      send_item(8'($urandom), 1'b0, 1'b1, 1'b0, '0);
      used++;
    end
  endtask

  // Mostly short messages, with a share of lengths around the point where
  // padding spills into a second block and around a full block.
  task automatic run_phase(input int budget, input int first_len, input logic leave_open);
    int sent, used, len, pick, i;
    sent = 0;
    len  = first_len;
    while (sent < budget) begin
      send_message(len, used);
      sent += used;
      if ($urandom_range(5) == 0) hold_until_drained();
      pick = $urandom_range(99);
      if (pick < 70) len = $urandom_range(8);
      else if (pick < 90) len = $urandom_range(57, 54);
      else len = $urandom_range(65, 63);
    end
    // A few bytes of an unfinished message, so that the next mode write
    // lands in the middle of a message.
    if (leave_open) begin
      len = $urandom_range(6, 1);
      for (i = 0; i < len; i++) send_item(8'($urandom), 1'b1, 1'b0, 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  task automatic report_error(input string msg);
    $display("ERROR at %0t ns: %s", $realtime, msg);
    error_count++;
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // A word is taken at the next rising edge when both sides are high here.
  always @(negedge clk) begin
    digest_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_words.size() == 0) begin
        report_error($sformatf("digest word %h with none expected", out_tdata));
      end else begin
        want = pending_words.pop_front();
        if (out_tdata !== want.word)
          report_error($sformatf("digest_word %h, expected %h", out_tdata, want.word));
        if (out_tuser !== want.index)
          report_error($sformatf("word_index %0d, expected %0d", out_tuser, want.index));
        if (out_tlast !== want.last)
          report_error($sformatf("last_word %b, expected %b at index %0d",
                                 out_tlast, want.last, want.index));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    uuid_en = 1'b0;
    restart_message();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Sender gaps light, receiver stalls heavy.
    tx_gap_pct   = 35;
    rx_stall_pct = 73;
    set_uuid_mode(1'b0);
    foreach (directed_rows[r])
      send_item(directed_rows[r].data, directed_rows[r].present, directed_rows[r].eom,
                directed_rows[r].known, directed_rows[r].digest);

    set_uuid_mode(1'b1);
    run_phase(75, 56, 1'b1);

    // Sender gaps heavy, receiver stalls light.
    tx_gap_pct   = 73;
    rx_stall_pct = 35;
    set_uuid_mode(1'b0);
    run_phase(75, 55, 1'b1);

    // Back to back in both directions.
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    set_uuid_mode(1'b1);
    run_phase(75, 64, 1'b0);

    in_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("** sha1_digest_engine_core: PASSED **");
    else
      $display("** sha1_digest_engine_core: FAILED **");
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timeout with %0d digest words outstanding", pending_words.size());
    $display("** sha1_digest_engine_core: FAILED **");
    $finish;
  end

endmodule
